// File: rtl/noise_gate_hold_attack_release_top_macros.svh
// assertion macros for the noise gate top level
// no dependencies; included by noise_gate_hold_attack_release_top.sv
`ifndef NOISE_GATE_HOLD_ATTACK_RELEASE_TOP_MACROS_SVH
`define NOISE_GATE_HOLD_ATTACK_RELEASE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define NGH_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NGH_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ngh_pkg.sv
// shared types and constants for the noise gate
// no dependencies; imported by every module of the block
package ngh_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int MAG_BITS       = SAMPLE_BITS - 1;
    localparam int COUNT_BITS     = 21;
    localparam int GAIN_BITS      = 17;
    localparam int COEF_BITS      = 16;
    localparam int THR_BITS       = 23;
    localparam int LEN_BITS       = 20;
    localparam int FRAC_BITS      = 16;
    localparam int QUO_BITS       = 16;
    localparam int CFG_DATA_BITS  = 23;
    localparam int CFG_INDEX_BITS = 3;

    // shared multiplier: signed sample-wide operand by signed gain-wide operand
    localparam int MUL_A_BITS = SAMPLE_BITS + 1;
    localparam int MUL_B_BITS = GAIN_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = MAG_BITS + FRAC_BITS + 1;

    localparam int DIV_STEPS    = QUO_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam logic [GAIN_BITS-1:0]  UNITY_GAIN = GAIN_BITS'(65536);
    localparam logic [GAIN_BITS-1:0]  SQRT2_Q16  = GAIN_BITS'(92681);
    localparam logic [MAG_BITS-1:0]   MAG_MAX    = {MAG_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    // register reset values
    localparam logic [COEF_BITS-1:0] SMOOTHING_RST = COEF_BITS'(64881);
    localparam logic [THR_BITS-1:0]  LOWER_THR_RST = THR_BITS'(83886);
    localparam logic [LEN_BITS-1:0]  HOLD_RST      = LEN_BITS'(4800);
    localparam logic [LEN_BITS-1:0]  ATTACK_RST    = LEN_BITS'(48);
    localparam logic [LEN_BITS-1:0]  RELEASE_RST   = LEN_BITS'(4800);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_THR = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD      = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK    = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE   = CFG_INDEX_BITS'(4);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_DIV,
        S_APPLY,
        S_MULG,
        S_DONE
    } state_t;

    typedef enum logic {
        DIV_RAMP,
        DIV_ATTACK
    } div_mode_t;

    typedef struct packed {
        state_t phase;
        logic   accept;
        logic   load_out;
    } ctrl_t;

    typedef struct packed {
        logic go_div;
    } status_t;

endpackage

// File: rtl/noise_gate_hold_attack_release_top.sv
// top level of the noise gate with hysteresis, hold, attack and release
// depends on ngh_pkg, ngh_ctrl, ngh_dp and the assertion macro header
`include "noise_gate_hold_attack_release_top_macros.svh"

// usage
// - input channel s_valid/s_ready/s_sample: one signed q1.23 sample per transaction
// - result channel m_valid/m_ready carries m_gated_sample (sample times gain,
//   floored) and m_gate_gain (q1.16, 65536 is unity), one result per sample
// - cfg_we/cfg_index/cfg_wdata write one register per cycle, no wait state;
//   indexes: smoothing, lower threshold, hold, attack, release; others ignored
// - write configuration only while no sample is in flight
// sequencing
// - phases: envelope and threshold products, compare, divide and apply (only
//   when the gain ramp or attack step needs the 16-step serial divider), output
//   product and done; s_ready is high only in idle: one sample at a time
// - the single multiplier is shared by envelope, threshold and output products,
//   so those products run one per cycle in sequence
// reset and stalls
// - aresetn (synchronous, active low) restores register defaults, clears the
//   envelope and hold count and sets unity gain
// - the result sits in an output register; a new sample is taken while it waits,
//   and the sequencer only stalls at the end if the previous result is unclaimed
module noise_gate_hold_attack_release_top
    import ngh_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_gated_sample,
    output logic [GAIN_BITS-1:0]          m_gate_gain,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata
);

    ctrl_t   ctrl;
    status_t status;

    // sequencer: walks the phases of one sample and owns the output valid
    ngh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    // datapath: envelope, gate decision, shared multiplier and divider step
    ngh_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_sample       (s_sample),
        .m_gated_sample (m_gated_sample),
        .m_gate_gain    (m_gate_gain),
        .ctrl           (ctrl),
        .status         (status)
    );

    // gain never exceeds unity
    `NGH_ASSERT_IMP(a_gain_le_unity, aclk, aresetn, m_valid, m_gate_gain <= UNITY_GAIN, "gain above unity")

    // a closed gate yields silence
    `NGH_ASSERT_IMP(a_closed_silent, aclk, aresetn, m_valid && (m_gate_gain == '0), m_gated_sample == '0, "closed gate passes signal")

    // one sample at a time: input closes after a transaction
    `NGH_ASSERT_NXT(a_single_item, aclk, aresetn, s_valid && s_ready, !s_ready, "input still ready after transaction")

endmodule

// File: rtl/ngh_ctrl.sv
// sequencer for the noise gate: phase, divider step count, output valid
// depends on ngh_pkg
module ngh_ctrl
    import ngh_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output ctrl_t   ctrl
);

    state_t                  state_reg;
    state_t                  state_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    div_last;
    logic                    out_free;

    assign div_last = (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1));
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_CMP;
            S_CMP:   state_next = status.go_div ? S_DIV : S_MULG;
            S_DIV: begin
                if (div_last) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: state_next = S_MULG;
            S_MULG:  state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        ctrl.phase    = state_reg;
        ctrl.accept   = (state_reg == S_IDLE) && s_valid;
        ctrl.load_out = (state_reg == S_DONE) && out_free;
        m_valid       = m_valid_reg;
    end

    always_comb begin
        div_cnt_next = div_cnt_reg;
        if (state_reg == S_CMP) begin
            div_cnt_next = '0;
        end else if (state_reg == S_DIV) begin
            div_cnt_next = div_cnt_reg + DIV_CNT_BITS'(1);
        end
        m_valid_next = m_valid_reg;
        if (ctrl.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/ngh_dp.sv
// noise gate datapath: registers, shared multiplier, serial divider step
// depends on ngh_pkg; driven by ngh_ctrl
module ngh_dp
    import ngh_pkg::*;
(
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [CFG_DATA_BITS-1:0]         cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample,
    output logic signed [SAMPLE_BITS-1:0]    m_gated_sample,
    output logic [GAIN_BITS-1:0]             m_gate_gain,
    input  ctrl_t                            ctrl,
    output status_t                          status
);

    // configuration
    logic [COEF_BITS-1:0] smoothing_reg;
    logic [THR_BITS-1:0]  lower_thr_reg;
    logic [LEN_BITS-1:0]  hold_reg;
    logic [LEN_BITS-1:0]  attack_reg;
    logic [LEN_BITS-1:0]  release_reg;

    // working registers
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [MAG_BITS-1:0]           mag_reg, mag_next;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic [ACC_BITS-1:0]           acc_reg, acc_next;
    logic [MAG_BITS-1:0]           env_reg, env_next;
    logic [GAIN_BITS-1:0]          gain_reg, gain_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic [LEN_BITS-1:0]           rem_reg, rem_next;
    logic [LEN_BITS-1:0]           divisor_reg, divisor_next;
    logic [QUO_BITS-1:0]           quo_reg, quo_next;
    div_mode_t                     div_mode_reg, div_mode_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic [GAIN_BITS-1:0]          out_gain_reg, out_gain_next;

    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   product;

    logic [SAMPLE_BITS-1:0]        neg_sample;
    logic [MAG_BITS-1:0]           mag_in;
    logic [ACC_BITS:0]             env_sum;
    logic [MAG_BITS:0]             upper;
    logic                          is_below;
    logic                          is_above;
    logic [COUNT_BITS-1:0]         count_inc;
    logic [COUNT_BITS-1:0]         past_diff;
    logic                          past_hold;
    logic                          in_ramp;
    logic                          att_short;
    logic [LEN_BITS:0]             rem_shift;
    logic [LEN_BITS:0]             rem_diff;
    logic                          div_ge;
    logic [GAIN_BITS-1:0]          ramp;
    logic [QUO_BITS-1:0]           step;
    logic [GAIN_BITS:0]            gain_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smoothing_reg <= SMOOTHING_RST;
            lower_thr_reg <= LOWER_THR_RST;
            hold_reg      <= HOLD_RST;
            attack_reg    <= ATTACK_RST;
            release_reg   <= RELEASE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SMOOTHING: smoothing_reg <= cfg_wdata[COEF_BITS-1:0];
                REG_LOWER_THR: lower_thr_reg <= cfg_wdata[THR_BITS-1:0];
                REG_HOLD:      hold_reg      <= cfg_wdata[LEN_BITS-1:0];
                REG_ATTACK:    attack_reg    <= cfg_wdata[LEN_BITS-1:0];
                REG_RELEASE:   release_reg   <= cfg_wdata[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // magnitude, most negative value saturates
    assign neg_sample = ~s_sample + SAMPLE_BITS'(1);
    always_comb begin
        if (!s_sample[SAMPLE_BITS-1]) begin
            mag_in = s_sample[MAG_BITS-1:0];
        end else if (neg_sample[SAMPLE_BITS-1]) begin
            mag_in = MAG_MAX;
        end else begin
            mag_in = neg_sample[MAG_BITS-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.phase)
            S_MUL0: begin
                mul_a = MUL_A_BITS'(env_reg);
                mul_b = MUL_B_BITS'(smoothing_reg);
            end
            S_MUL1: begin
                mul_a = MUL_A_BITS'(mag_reg);
                mul_b = MUL_B_BITS'(UNITY_GAIN - GAIN_BITS'(smoothing_reg));
            end
            S_MUL2: begin
                mul_a = MUL_A_BITS'(lower_thr_reg);
                mul_b = MUL_B_BITS'(SQRT2_Q16);
            end
            S_MULG: begin
                mul_a = MUL_A_BITS'(sample_reg);
                mul_b = MUL_B_BITS'(gain_reg);
            end
            default: ;
        endcase
    end
    assign product = mul_a * mul_b;

    assign env_sum   = {1'b0, acc_reg} + {1'b0, prod_reg[ACC_BITS-1:0]};
    assign upper     = prod_reg[MAG_BITS+FRAC_BITS:FRAC_BITS];
    assign is_below  = (env_reg <= lower_thr_reg) && ({1'b0, env_reg} < upper);
    assign is_above  = ({1'b0, env_reg} >= upper) && (env_reg > lower_thr_reg);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg
                                                : count_reg + COUNT_BITS'(1);
    assign past_hold = count_inc > COUNT_BITS'(hold_reg);
    assign past_diff = count_inc - COUNT_BITS'(hold_reg);
    assign in_ramp   = past_diff < COUNT_BITS'(release_reg);
    assign att_short = attack_reg <= LEN_BITS'(1);

    assign status.go_div = (ctrl.phase == S_CMP)
                         && ((is_below && past_hold && in_ramp) || (is_above && !att_short));

    // restoring divider step, one quotient bit a cycle
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign div_ge    = rem_shift >= {1'b0, divisor_reg};

    assign ramp     = UNITY_GAIN - GAIN_BITS'(quo_reg);
    assign step     = (quo_reg == '0) ? QUO_BITS'(1) : quo_reg;
    assign gain_sum = {1'b0, gain_reg} + (GAIN_BITS + 1)'(step);

    always_comb begin
        sample_next     = sample_reg;
        mag_next        = mag_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        env_next        = env_reg;
        gain_next       = gain_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        quo_next        = quo_reg;
        div_mode_next   = div_mode_reg;
        out_sample_next = out_sample_reg;
        out_gain_next   = out_gain_reg;
        case (ctrl.phase)
            S_IDLE: begin
                if (ctrl.accept) begin
                    sample_next = s_sample;
                    mag_next    = mag_in;
                end
            end
            S_MUL0: prod_next = product;
            S_MUL1: begin
                prod_next = product;
                acc_next  = prod_reg[ACC_BITS-1:0];
            end
            S_MUL2: begin
                prod_next = product;
                env_next  = env_sum[MAG_BITS+FRAC_BITS-1:FRAC_BITS];
            end
            S_CMP: begin
                quo_next = '0;
                if (is_below) begin
                    count_next = count_inc;
                    if (past_hold) begin
                        if (in_ramp) begin
                            rem_next      = past_diff[LEN_BITS-1:0];
                            divisor_next  = release_reg;
                            div_mode_next = DIV_RAMP;
                        end else begin
                            gain_next = '0;
                        end
                    end
                end else if (is_above) begin
                    count_next = '0;
                    if (att_short) begin
                        gain_next = UNITY_GAIN;
                    end else begin
                        rem_next      = LEN_BITS'(1);
                        divisor_next  = attack_reg;
                        div_mode_next = DIV_ATTACK;
                    end
                end else begin
                    count_next = '0;
                end
            end
            S_DIV: begin
                rem_next = div_ge ? rem_diff[LEN_BITS-1:0] : rem_shift[LEN_BITS-1:0];
                quo_next = {quo_reg[QUO_BITS-2:0], div_ge};
            end
            S_APPLY: begin
                if (div_mode_reg == DIV_RAMP) begin
                    if (ramp < gain_reg) begin
                        gain_next = ramp;
                    end
                end else if (gain_sum > (GAIN_BITS + 1)'(UNITY_GAIN)) begin
                    gain_next = UNITY_GAIN;
                end else begin
                    gain_next = gain_sum[GAIN_BITS-1:0];
                end
            end
            S_MULG: prod_next = product;
            S_DONE: begin
                if (ctrl.load_out) begin
                    out_sample_next = prod_reg[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];
                    out_gain_next   = gain_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg   <= '0;
            gain_reg  <= UNITY_GAIN;
            count_reg <= '0;
        end else begin
            env_reg   <= env_next;
            gain_reg  <= gain_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        mag_reg        <= mag_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        quo_reg        <= quo_next;
        div_mode_reg   <= div_mode_next;
        out_sample_reg <= out_sample_next;
        out_gain_reg   <= out_gain_next;
    end

    assign m_gated_sample = out_sample_reg;
    assign m_gate_gain    = out_gain_reg;

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the noise gate with hold, attack and release
// depends on ngh_pkg and noise_gate_hold_attack_release_top
// a scoreboard class tracks envelope, hold count and gain and checks every result
module tb_top;
    import ngh_pkg::*;

    // arithmetic limits in wide form for the gate tracker
    localparam longint GAIN_ONE    = longint'(UNITY_GAIN);
    localparam longint SQRT2_FIX   = longint'(SQRT2_Q16);
    localparam longint MAG_LIMIT   = longint'(MAG_MAX);
    localparam longint COUNT_LIMIT = longint'(COUNT_MAX);

    // cycles to let the sequencer settle before touching registers
    localparam int SETTLE_CYCLES = 40;
    // long receiver hold-off, started once after this many results
    localparam int HOLD_OFF_AT     = 700;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 200;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] gated;
        logic [GAIN_BITS-1:0]          gain;
    } gate_out_t;

    // tracks the gate state and holds the results still owed by the block
    class gate_checker;
        longint smoothing, lower_thr, hold_len, attack_len, release_len;
        longint envelope, gain, below_count;
        gate_out_t owed_q[$];
        int errors;

        function new();
            smoothing   = longint'(SMOOTHING_RST);
            lower_thr   = longint'(LOWER_THR_RST);
            hold_len    = longint'(HOLD_RST);
            attack_len  = longint'(ATTACK_RST);
            release_len = longint'(RELEASE_RST);
            envelope    = 0;
            gain        = GAIN_ONE;
            below_count = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_SMOOTHING: smoothing   = data[COEF_BITS-1:0];
                REG_LOWER_THR: lower_thr   = data[THR_BITS-1:0];
                REG_HOLD:      hold_len    = data[LEN_BITS-1:0];
                REG_ATTACK:    attack_len  = data[LEN_BITS-1:0];
                REG_RELEASE:   release_len = data[LEN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // one accepted sample: advance envelope, count and gain, owe one result
        function void take_sample(logic signed [SAMPLE_BITS-1:0] sample);
            longint s, mag, acc, upper, d, ramp, step, gated;
            gate_out_t owed;
            s   = sample;
            mag = (s < 0) ? -s : s;
            if (mag > MAG_LIMIT) mag = MAG_LIMIT;
            acc      = smoothing * envelope + (GAIN_ONE - smoothing) * mag;
            envelope = (acc >> FRAC_BITS) & MAG_LIMIT;
            upper    = (lower_thr * SQRT2_FIX) >> FRAC_BITS;
            if (envelope <= lower_thr && envelope < upper) begin
                if (below_count < COUNT_LIMIT) below_count++;
                if (below_count > hold_len) begin
                    d = below_count - hold_len;
                    if (d < release_len) begin
                        ramp = GAIN_ONE - (d * GAIN_ONE) / release_len;
                        if (ramp < gain) gain = ramp;
                    end else begin
                        gain = 0;
                    end
                end
            end else if (envelope >= upper && envelope > lower_thr) begin
                step = GAIN_ONE / ((attack_len == 0) ? 1 : attack_len);
                if (step == 0) step = 1;
                below_count = 0;
                gain = gain + step;
                if (gain > GAIN_ONE) gain = GAIN_ONE;
            end else begin
                below_count = 0;
            end
            gated      = (s * gain) >>> FRAC_BITS;
            owed.gated = gated[SAMPLE_BITS-1:0];
            owed.gain  = gain[GAIN_BITS-1:0];
            owed_q.push_back(owed);
        endfunction

        function void check_output(logic signed [SAMPLE_BITS-1:0] got_sample,
                                   logic [GAIN_BITS-1:0] got_gain);
            gate_out_t want;
            if (owed_q.size() == 0) begin
                $error("result with nothing owed: gated_sample %0d gate_gain %0d",
                       got_sample, got_gain);
                errors++;
            end else begin
                want = owed_q.pop_front();
                if (got_sample !== want.gated) begin
                    $error("gated_sample: expected %0d, actual %0d", want.gated, got_sample);
                    errors++;
                end
                if (got_gain !== want.gain) begin
                    $error("gate_gain: expected %0d, actual %0d", want.gain, got_gain);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample  = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_gated_sample;
    logic [GAIN_BITS-1:0]          m_gate_gain;
    logic                          cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata = '0;

    gate_checker gate = new();

    // idle rates in percent, swapped part-way and then dropped
    int send_idle_pct = 20;
    int recv_idle_pct = 58;
    // close threshold currently programmed, steers the random sample levels
    longint cur_lower = longint'(LOWER_THR_RST);
    int results_seen = 0;
    int hold_off_left = 0;

    noise_gate_hold_attack_release_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gated_sample (m_gated_sample),
        .m_gate_gain    (m_gate_gain),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: check each transaction, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            gate.check_output(m_gated_sample, m_gate_gain);
            results_seen++;
            // one long hold-off so the output register fills and s_ready drops
            if (results_seen == HOLD_OFF_AT) hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one sample, with an optional random gap first; returns on the
    // edge that takes the transaction, valid still high
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sample);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid  <= 1'b1;
        s_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        gate.take_sample(sample);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, longint unsigned data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[CFG_DATA_BITS-1:0];
        gate.write_reg(idx, data[CFG_DATA_BITS-1:0]);
        @(posedge aclk);
    endtask

    // registers only change once the block has drained and gone quiet
    task automatic write_settings(longint unsigned smooth, longint unsigned lower,
                                  longint unsigned hold, longint unsigned attack,
                                  longint unsigned rel);
        logic [CFG_INDEX_BITS-1:0] junk_idx;
        // drop valid straight away so the last sample is not taken twice
        s_valid <= 1'b0;
        while (gate.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write(REG_SMOOTHING, smooth);
        cfg_write(REG_LOWER_THR, lower);
        cfg_write(REG_HOLD, hold);
        cfg_write(REG_ATTACK, attack);
        cfg_write(REG_RELEASE, rel);
        // an index past the last register must be ignored
        junk_idx = CFG_INDEX_BITS'($urandom_range(7, int'(REG_RELEASE) + 1));
        cfg_write(junk_idx, {$urandom, $urandom});
        cfg_we    <= 1'b0;
        cur_lower = lower & ((longint'(1) << THR_BITS) - 1);
    endtask

    // settings drawn with a strong lean towards the extremes
    task automatic random_settings();
        longint unsigned smooth, lower, hold, attack, rel;
        case ($urandom_range(3))
            0: smooth = 0;
            1: smooth = 65535;
            2: smooth = $urandom_range(65535);
            default: smooth = $urandom_range(16384);
        endcase
        case ($urandom_range(4))
            0: lower = 0;
            1: lower = 8388607;
            default: lower = $urandom_range(1 << 20, 1);
        endcase
        case ($urandom_range(5))
            0: hold = 0;
            1: hold = 1048575;
            default: hold = $urandom_range(40);
        endcase
        case ($urandom_range(4))
            0: attack = 0;
            1: attack = 1048575;
            2: attack = 1;
            default: attack = $urandom_range(64, 1);
        endcase
        case ($urandom_range(4))
            0: rel = 0;
            1: rel = 1048575;
            2: rel = 1;
            default: rel = $urandom_range(64, 1);
        endcase
        write_settings(smooth, lower, hold, attack, rel);
    endtask

    // runs of loud, quiet and in-band material around the current threshold,
    // with short bursts of raw noise in between
    task automatic random_phase(int count);
        int left, run_len, kind, sv;
        longint lo, hi;
        logic signed [SAMPLE_BITS-1:0] sample;
        left = count;
        while (left > 0) begin
            kind = $urandom_range(99);
            if (kind < 40)      run_len = $urandom_range(40, 1);
            else if (kind < 75) run_len = $urandom_range(120, 1);
            else if (kind < 88) run_len = $urandom_range(20, 1);
            else                run_len = $urandom_range(3, 1);
            if (run_len > left) run_len = left;
            for (int i = 0; i < run_len; i++) begin
                if (kind < 40) begin
                    // well above the open threshold
                    lo = 2 * cur_lower + 1;
                    if (lo > MAG_LIMIT) lo = MAG_LIMIT;
                    sv = $urandom_range(int'(MAG_LIMIT), int'(lo));
                end else if (kind < 75) begin
                    sv = $urandom_range(int'(cur_lower / 2));
                end else if (kind < 88) begin
                    // around the hysteresis band
                    hi = cur_lower + cur_lower / 2;
                    if (hi > MAG_LIMIT) hi = MAG_LIMIT;
                    sv = $urandom_range(int'(hi), int'(cur_lower));
                end else begin
                    sv = $urandom;
                end
                if (kind < 88 && $urandom_range(1)) sv = -sv;
                sample = sv[SAMPLE_BITS-1:0];
                send_sample(sample);
            end
            left -= run_len;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: field extremes, most negative sample saturates
        send_sample(0);
        send_sample(8388607);
        send_sample(-8388608);
        send_sample(-1);

        // instant envelope, no hold, zero attack steps straight to unity,
        // zero release closes right away
        write_settings(0, 1000, 0, 0, 0);
        send_sample(10);
        send_sample(-8388608);
        send_sample(1200);
        send_sample(5);
        send_sample(1);

        // zero threshold: nothing is below, a silent envelope sits in the band
        write_settings(0, 0, 2, 3, 4);
        send_sample(0);
        send_sample(1);
        send_sample(-1);

        // hold for two samples, ramp down over four, then climb in thirds
        write_settings(0, 100, 2, 3, 4);
        repeat (7) send_sample(0);
        repeat (4) send_sample(8388607);

        // every register at its top value
        write_settings(65535, 8388607, 1048575, 1048575, 1048575);
        random_phase(100);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_settings();
            if (p == 3) begin
                send_idle_pct = 58;
                recv_idle_pct = 20;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase(PHASE_ITEMS);
        end

        s_valid <= 1'b0;
        while (gate.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (gate.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
